>>> design/segment_pointer_to_index_expander_macros.svh
// Assertion macros shared by the checker.
`ifndef SEGMENT_POINTER_TO_INDEX_EXPANDER_MACROS_SVH
`define SEGMENT_POINTER_TO_INDEX_EXPANDER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SPIE_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("spie check failed");

// Next-cycle implication, disabled while in reset.
`define SPIE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("spie check failed");

`endif

>>> design/spie_pkg.sv
package spie_pkg;

    // Field widths
    localparam int OP_W         = 2;
    localparam int TABLE_IDX_W  = 11;
    localparam int VALUE_W      = 32;
    localparam int SEG_IDX_W    = 11;
    localparam int POS_W        = 32;
    localparam int TOTAL_W      = 32;
    localparam int NUM_SEG_W    = 11;

    // Stream widths; tdata padded to whole bytes
    localparam int S_TDATA_W    = 48;
    localparam int S_TUSER_W    = OP_W;
    localparam int M_TDATA_W    = 48;
    localparam int M_TUSER_W    = 1;

    // Configuration port
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_ELEMENTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SEGMENTS   = 2'd1;

    localparam int DEFAULT_MAX_SEGMENTS = 1024;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_SEEK  = 2'd1,
        OP_NEXT  = 2'd2
    } op_e;

    // Command handed from front to back through the queue
    typedef struct packed {
        op_e                    op;
        logic [TABLE_IDX_W-1:0] table_index;
        logic [VALUE_W-1:0]     value;
    } cmd_t;

    // Configuration registers seen by the back end
    typedef struct packed {
        logic [TOTAL_W-1:0]   total_elements;
        logic [NUM_SEG_W-1:0] num_segments;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEEK_RD,
        ST_SEEK_CMP,
        ST_SEEK_END,
        ST_NEXT_CHK,
        ST_NEXT_WAIT
    } back_state_e;

endpackage

>>> design/spie_front.sv
module spie_front #(
    parameter int MAX_SEGMENTS = spie_pkg::DEFAULT_MAX_SEGMENTS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [spie_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [spie_pkg::S_TUSER_W-1:0]   s_tuser,
    // config writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [spie_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [spie_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output spie_pkg::cfg_t                   cfg,
    // to queue
    output logic                             push_valid,
    input  logic                             push_ready,
    output spie_pkg::cmd_t                   push_cmd
);

    logic [spie_pkg::TOTAL_W-1:0]   total_reg;
    logic [spie_pkg::NUM_SEG_W-1:0] num_seg_reg;
    logic                           keep;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg   <= '0;
            num_seg_reg <= spie_pkg::NUM_SEG_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                spie_pkg::CFG_TOTAL_ELEMENTS: begin
                    total_reg <= cfg_wdata[spie_pkg::TOTAL_W-1:0];
                end
                spie_pkg::CFG_NUM_SEGMENTS: begin
                    num_seg_reg <= cfg_wdata[spie_pkg::NUM_SEG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg.total_elements = total_reg;
    assign cfg.num_segments   = num_seg_reg;

    // unpack and classify
    assign push_cmd.op          = spie_pkg::op_e'(s_tuser[spie_pkg::OP_W-1:0]);
    assign push_cmd.table_index = s_tdata[spie_pkg::TABLE_IDX_W-1:0];
    assign push_cmd.value       =
        s_tdata[spie_pkg::TABLE_IDX_W +: spie_pkg::VALUE_W];

    // unknown ops and writes past the table end are dropped here
    always_comb begin
        case (push_cmd.op)
            spie_pkg::OP_WRITE: begin
                keep = (32'(push_cmd.table_index) <= 32'(MAX_SEGMENTS));
            end
            spie_pkg::OP_SEEK,
            spie_pkg::OP_NEXT: begin
                keep = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid && keep;

endmodule

>>> design/spie_queue.sv
module spie_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  spie_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output spie_pkg::cmd_t pop_cmd
);

    // two-entry ring
    spie_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> design/spie_back.sv
module spie_back #(
    parameter int MAX_SEGMENTS = spie_pkg::DEFAULT_MAX_SEGMENTS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  spie_pkg::cfg_t                  cfg,
    // from queue
    input  logic                            pop_valid,
    output logic                            pop_ready,
    input  spie_pkg::cmd_t                  pop_cmd,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [spie_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [spie_pkg::M_TUSER_W-1:0]  m_tuser
);

    localparam int SW    = $clog2(MAX_SEGMENTS + 1);
    localparam int DEPTH = MAX_SEGMENTS + 1;

    // pointer table
    logic [spie_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [spie_pkg::VALUE_W-1:0] rd_data_reg;
    logic [SW-1:0]                rd_addr;
    logic                         rd_en;
    logic                         wr_en;

    spie_pkg::back_state_e state_reg, state_next;
    logic [SW-1:0]                 lo_reg, lo_next;
    logic [SW-1:0]                 hip1_reg, hip1_next;
    logic [SW-1:0]                 mid_reg, mid_next;
    logic [SW-1:0]                 found_reg, found_next;
    logic [spie_pkg::VALUE_W-1:0]  start_reg, start_next;
    logic [SW-1:0]                 cur_seg_reg, cur_seg_next;
    logic [spie_pkg::POS_W:0]      seg_end_reg, seg_end_next;
    logic [spie_pkg::POS_W-1:0]    cur_pos_reg, cur_pos_next;

    logic                          out_valid_reg, out_valid_next;
    logic [spie_pkg::SEG_IDX_W-1:0] out_seg_reg, out_seg_next;
    logic [spie_pkg::POS_W-1:0]    out_pos_reg, out_pos_next;
    logic                          out_past_reg, out_past_next;

    logic [SW-1:0]                 seg_count;
    logic [SW:0]                   mid_sum;
    logic [SW-1:0]                 seg_inc;

    // clamp the configured segment count into 1 .. MAX_SEGMENTS
    always_comb begin
        if (cfg.num_segments == '0) begin
            seg_count = SW'(1);
        end else if (32'(cfg.num_segments) > 32'(MAX_SEGMENTS)) begin
            seg_count = SW'(MAX_SEGMENTS);
        end else begin
            seg_count = SW'(cfg.num_segments);
        end
    end

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hip1_reg} - (SW+1)'(1);
    assign seg_inc = cur_seg_reg + SW'(1);

    // table write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[SW'(pop_cmd.table_index)] <= pop_cmd.value;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= spie_pkg::ST_IDLE;
            cur_seg_reg   <= '0;
            seg_end_reg   <= '0;
            cur_pos_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cur_seg_reg   <= cur_seg_next;
            seg_end_reg   <= seg_end_next;
            cur_pos_reg   <= cur_pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg      <= lo_next;
        hip1_reg    <= hip1_next;
        mid_reg     <= mid_next;
        found_reg   <= found_next;
        start_reg   <= start_next;
        out_seg_reg <= out_seg_next;
        out_pos_reg <= out_pos_next;
        out_past_reg <= out_past_next;
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hip1_next      = hip1_reg;
        mid_next       = mid_reg;
        found_next     = found_reg;
        start_next     = start_reg;
        cur_seg_next   = cur_seg_reg;
        seg_end_next   = seg_end_reg;
        cur_pos_next   = cur_pos_reg;
        out_seg_next   = out_seg_reg;
        out_pos_next   = out_pos_reg;
        out_past_next  = out_past_reg;
        out_valid_next = out_valid_reg && !m_tready;
        pop_ready      = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = '0;

        case (state_reg)
            spie_pkg::ST_IDLE: begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    case (pop_cmd.op)
                        spie_pkg::OP_WRITE: begin
                            wr_en = 1'b1;
                        end
                        spie_pkg::OP_SEEK: begin
                            lo_next    = '0;
                            hip1_next  = seg_count;
                            found_next = '0;
                            start_next = pop_cmd.value;
                            state_next = spie_pkg::ST_SEEK_RD;
                        end
                        spie_pkg::OP_NEXT: begin
                            state_next = spie_pkg::ST_NEXT_CHK;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // one probe of the binary search, or fetch of the end pointer
            spie_pkg::ST_SEEK_RD: begin
                rd_en = 1'b1;
                if (lo_reg < hip1_reg) begin
                    mid_next   = mid_sum[SW:1];
                    rd_addr    = mid_sum[SW:1];
                    state_next = spie_pkg::ST_SEEK_CMP;
                end else begin
                    rd_addr    = found_reg + SW'(1);
                    state_next = spie_pkg::ST_SEEK_END;
                end
            end

            spie_pkg::ST_SEEK_CMP: begin
                if (rd_data_reg <= start_reg) begin
                    found_next = mid_reg;
                    lo_next    = mid_reg + SW'(1);
                end else begin
                    hip1_next  = mid_reg;
                end
                state_next = spie_pkg::ST_SEEK_RD;
            end

            spie_pkg::ST_SEEK_END: begin
                cur_seg_next = found_reg;
                seg_end_next = {1'b0, rd_data_reg};
                cur_pos_next = start_reg;
                state_next   = spie_pkg::ST_IDLE;
            end

            // step over finished segments, else emit
            spie_pkg::ST_NEXT_CHK: begin
                if (({1'b0, cur_pos_reg} >= seg_end_reg) && (cur_seg_reg < seg_count)) begin
                    cur_seg_next = seg_inc;
                    if (seg_inc < seg_count) begin
                        rd_en      = 1'b1;
                        rd_addr    = seg_inc + SW'(1);
                        state_next = spie_pkg::ST_NEXT_WAIT;
                    end else begin
                        seg_end_next = (spie_pkg::POS_W+1)'(cfg.total_elements)
                                     + (spie_pkg::POS_W+1)'(1);
                    end
                end else if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_seg_next   = spie_pkg::SEG_IDX_W'(cur_seg_reg);
                    out_pos_next   = cur_pos_reg;
                    out_past_next  = (cur_pos_reg >= cfg.total_elements);
                    cur_pos_next   = cur_pos_reg + spie_pkg::POS_W'(1);
                    state_next     = spie_pkg::ST_IDLE;
                end
            end

            spie_pkg::ST_NEXT_WAIT: begin
                seg_end_next = {1'b0, rd_data_reg};
                state_next   = spie_pkg::ST_NEXT_CHK;
            end

            default: begin
                state_next = spie_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(spie_pkg::M_TDATA_W - spie_pkg::SEG_IDX_W - spie_pkg::POS_W){1'b0}},
                       out_pos_reg, out_seg_reg};
    assign m_tuser  = out_past_reg;

endmodule

>>> design/segment_pointer_to_index_expander.sv
// Segment pointer to index expander.
// Input stream s_*: s_tuser carries the op (0 write table entry, 1 seek,
// 2 emit next index); s_tdata carries table_index and value. Op 0 stores
// value at table_index, op 1 binary-searches the table for the segment
// holding position value, op 2 returns one result on m_*.
// Config channel cfg_*: index 0 total_elements, index 1 num_segments;
// always ready; the user writes it only while the block is idle (not enforced).
// A next item reads the table once for each segment end crossed (through
// the single read port) and takes one more step past the last segment;
// a seek makes at most floor(log2(n))+1 probes of the binary search for
// n segments.
// A two-entry command queue sits between front and back end, so input
// is taken while the back end is busy or a result waits.
// Reset (aresetn low, synchronous) clears position, segment and config;
// the pointer table holds no reset value and needs no clearing pass.
// When m_tready is low the result register holds and the back end stalls
// on its next emit; the queue fills and s_tready then drops.
module segment_pointer_to_index_expander #(
    parameter int MAX_SEGMENTS = spie_pkg::DEFAULT_MAX_SEGMENTS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: [10:0] table_index, [42:11] value, [47:43] zero
    input  logic [spie_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: [1:0] op
    input  logic [spie_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: [10:0] segment_index, [42:11] position, [47:43] zero
    output logic [spie_pkg::M_TDATA_W-1:0]  m_tdata,
    // m_tuser: [0] past_end
    output logic [spie_pkg::M_TUSER_W-1:0]  m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [spie_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spie_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    spie_pkg::cfg_t cfg;
    spie_pkg::cmd_t push_cmd;
    spie_pkg::cmd_t pop_cmd;
    logic           push_valid;
    logic           push_ready;
    logic           pop_valid;
    logic           pop_ready;

    spie_front #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    spie_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    spie_back #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

>>> design/spie_checker.sv
`include "segment_pointer_to_index_expander_macros.svh"

module spie_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [spie_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [spie_pkg::M_TUSER_W-1:0]  m_tuser,
    input logic                            cfg_valid,
    input logic                            cfg_ready
);

    // a stalled result stays offered
    `SPIE_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

    // a stalled result keeps its payload
    `SPIE_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))

    // no result right out of reset
    `SPIE_ASSERT_NOW(a_out_after_reset, aclk, aresetn, !$past(aresetn), !m_tvalid)

    // padding bits above position stay zero
    `SPIE_ASSERT_NOW(a_out_pad, aclk, aresetn, m_tvalid, m_tdata[47:43] == 5'd0)

    // config channel never back-pressures
    `SPIE_ASSERT_NOW(a_cfg_ready, aclk, aresetn, cfg_valid, cfg_ready)

endmodule

bind segment_pointer_to_index_expander spie_checker u_spie_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

>>> tb/tb_segment_pointer_to_index_expander.sv
module tb_segment_pointer_to_index_expander;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SEG      = spie_pkg::DEFAULT_MAX_SEGMENTS;
    localparam int RESET_CYCLES = 8;
    localparam int PHASE_ITEMS  = 6;
    localparam int DRAIN_CYCLES = 128;
    localparam int STALL_LIMIT  = 20000;
    localparam int MAX_REPORTS  = 10;
    localparam int S_PAD_W      = spie_pkg::S_TDATA_W - spie_pkg::TABLE_IDX_W
                                - spie_pkg::VALUE_W;

    // op code the block must ignore
    localparam logic [spie_pkg::OP_W-1:0] OP_RESERVED = 2'd3;

    typedef struct packed {
        logic [spie_pkg::OP_W-1:0]        op;
        logic [spie_pkg::TABLE_IDX_W-1:0] table_index;
        logic [spie_pkg::VALUE_W-1:0]     value;
    } stream_item_t;

    typedef struct packed {
        logic [spie_pkg::SEG_IDX_W-1:0] segment_index;
        logic [spie_pkg::POS_W-1:0]     position;
        logic                           past_end;
    } index_result_t;

    // DUT ports
    logic                            aclk;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    // s_tdata: [10:0] table_index, [42:11] value, [47:43] zero
    logic [spie_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    // s_tuser: [1:0] op
    logic [spie_pkg::S_TUSER_W-1:0]  s_tuser   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    // m_tdata: [10:0] segment_index, [42:11] position, [47:43] zero
    logic [spie_pkg::M_TDATA_W-1:0]  m_tdata;
    // m_tuser: [0] past_end
    logic [spie_pkg::M_TUSER_W-1:0]  m_tuser;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [spie_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [spie_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // result fields as seen on the port
    logic [spie_pkg::SEG_IDX_W-1:0]  got_seg;
    logic [spie_pkg::POS_W-1:0]      got_pos;
    logic                            got_past;

    // stimulus side
    stream_item_t  pending_items[$];
    stream_item_t  drive_item;
    logic [31:0]   plan_ptr [0:MAX_SEG];
    int            items_queued   = 0;
    int            items_accepted = 0;
    int            tx_idle_pct    = 0;
    int            rx_idle_pct    = 0;
    bit            in_fire        = 1'b0;

    // predicted block state
    logic [31:0]                    seg_ptr [0:MAX_SEG];
    logic [spie_pkg::TOTAL_W-1:0]   cfg_total   = '0;
    logic [spie_pkg::NUM_SEG_W-1:0] cfg_num_seg = 11'd1;
    int unsigned                    walk_seg    = 0;
    logic [32:0]                    walk_end    = '0;
    logic [31:0]                    walk_pos    = '0;

    // checking
    index_result_t expected_indices[$];
    index_result_t want_result;
    int            fail_count  = 0;
    int            stall_cycles = 0;

    segment_pointer_to_index_expander #(
        .MAX_SEGMENTS(MAX_SEG)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    assign got_seg  = m_tdata[spie_pkg::SEG_IDX_W-1:0];
    assign got_pos  = m_tdata[spie_pkg::SEG_IDX_W +: spie_pkg::POS_W];
    assign got_past = m_tuser[0];

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ---------------- predictor ----------------

    function automatic int unsigned seg_limit();
        if (cfg_num_seg == '0)
            return 1;
        if (32'(cfg_num_seg) > MAX_SEG)
            return MAX_SEG;
        return 32'(cfg_num_seg);
    endfunction

    function automatic logic [31:0] table_entry(input int unsigned i);
        return (i > MAX_SEG) ? 32'd0 : seg_ptr[i];
    endfunction

    task automatic expand_item(input stream_item_t it);
        int unsigned   n;
        int            lo;
        int            hi;
        int            mid;
        int unsigned   found;
        index_result_t res;
        n = seg_limit();
        case (it.op)
            spie_pkg::OP_WRITE: begin
                if (32'(it.table_index) <= MAX_SEG)
                    seg_ptr[it.table_index] = it.value;
            end
            spie_pkg::OP_SEEK: begin
                // last segment whose start is at or below the position
                lo = 0;
                hi = n - 1;
                found = 0;
                while (lo <= hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (table_entry(mid) <= it.value) begin
                        found = mid;
                        lo = mid + 1;
                    end else begin
                        hi = mid - 1;
                    end
                end
                walk_seg = found;
                walk_end = {1'b0, table_entry(found + 1)};
                walk_pos = it.value;
            end
            spie_pkg::OP_NEXT: begin
                // step over finished and empty segments, stop at the count
                while ({1'b0, walk_pos} >= walk_end && walk_seg < n) begin
                    walk_seg++;
                    if (walk_seg < n)
                        walk_end = {1'b0, table_entry(walk_seg + 1)};
                    else
                        walk_end = {1'b0, cfg_total} + 33'd1;
                end
                res.segment_index = walk_seg[spie_pkg::SEG_IDX_W-1:0];
                res.position      = walk_pos;
                res.past_end      = (walk_pos >= cfg_total);
                expected_indices.push_back(res);
                walk_pos = walk_pos + 32'd1;
            end
            default: ;
        endcase
    endtask

    // ---------------- input driver and idling ----------------

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        if (!s_tvalid || in_fire) begin
            if (aresetn && pending_items.size() != 0
                    && $urandom_range(0, 99) >= tx_idle_pct) begin
                drive_item = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= drive_item.op;
                s_tdata  <= {{S_PAD_W{1'b0}}, drive_item.value,
                             drive_item.table_index};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- monitor and scoreboard ----------------

    always @(posedge aclk) begin
        in_fire = aresetn && s_tvalid && s_tready;
        if (in_fire) begin
            items_accepted++;
            expand_item(drive_item);
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_indices.size() == 0) begin
                if (fail_count < MAX_REPORTS)
                    $display("unexpected result: seg %0d pos %h past_end %0b",
                             got_seg, got_pos, got_past);
                fail_count++;
            end else begin
                want_result = expected_indices.pop_front();
                if (got_seg !== want_result.segment_index
                        || got_pos !== want_result.position
                        || got_past !== want_result.past_end) begin
                    if (fail_count < MAX_REPORTS)
                        $display("mismatch: exp %0d %h %0b got %0d %h %0b",
                                 want_result.segment_index, want_result.position,
                                 want_result.past_end, got_seg, got_pos, got_past);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: no transfer of any kind for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------- stimulus helpers ----------------

    function automatic logic [spie_pkg::TABLE_IDX_W-1:0] rand_index();
        return spie_pkg::TABLE_IDX_W'($urandom_range(0, 2**spie_pkg::TABLE_IDX_W - 1));
    endfunction

    task automatic push_item(input logic [spie_pkg::OP_W-1:0] op,
                             input logic [spie_pkg::TABLE_IDX_W-1:0] idx,
                             input logic [spie_pkg::VALUE_W-1:0] val);
        stream_item_t it;
        it.op          = op;
        it.table_index = idx;
        it.value       = val;
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic next_burst(input int count);
        repeat (count) push_item(spie_pkg::OP_NEXT, rand_index(), $urandom());
    endtask

    // monotone pointer plan, about a third of the segments empty
    task automatic plan_table(input int n, input logic [31:0] base, input int max_gap);
        logic [32:0] acc;
        acc = {1'b0, base};
        for (int i = 0; i <= n; i++) begin
            plan_ptr[i] = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
            if ($urandom_range(0, 99) >= 30)
                acc = acc + 33'($urandom_range(1, max_gap));
        end
    endtask

    task automatic load_table(input int n);
        for (int i = 0; i <= n; i++)
            push_item(spie_pkg::OP_WRITE, spie_pkg::TABLE_IDX_W'(i), plan_ptr[i]);
    endtask

    // everything sent has been taken and answered, then let seeks settle
    task automatic wait_idle();
        @(negedge aclk);
        while (items_accepted != items_queued || expected_indices.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic config_write(input logic [spie_pkg::CFG_IDX_W-1:0] idx,
                                input logic [spie_pkg::CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == spie_pkg::CFG_TOTAL_ELEMENTS)
            cfg_total = data;
        else if (idx == spie_pkg::CFG_NUM_SEGMENTS)
            cfg_num_seg = data[spie_pkg::NUM_SEG_W-1:0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic begin_phase(input int tx_pct, input int rx_pct,
                               input logic [31:0] total, input logic [31:0] nseg_word);
        wait_idle();
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        config_write(spie_pkg::CFG_TOTAL_ELEMENTS, total);
        config_write(spie_pkg::CFG_NUM_SEGMENTS, nseg_word);
    endtask

    // mostly seek-then-walk runs; some bare walks, table rewrites,
    // wild seeks and reserved ops
    task automatic random_items(input int n, input int quota, input bit seek_first);
        int                               made;
        int                               r;
        int                               burst;
        logic [31:0]                      lo;
        logic [32:0]                      hi;
        logic [spie_pkg::TABLE_IDX_W-1:0] idx;
        logic [31:0]                      v;
        made = 0;
        if (seek_first) begin
            push_item(spie_pkg::OP_SEEK, rand_index(), plan_ptr[0]);
            made++;
        end
        while (made < quota) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                lo = (plan_ptr[0] > 32'd2) ? plan_ptr[0] - 32'd2 : 32'd0;
                hi = {1'b0, plan_ptr[n]} + 33'd3;
                v = hi[32] ? $urandom_range(32'hFFFF_FFFF, lo) : $urandom_range(hi[31:0], lo);
                push_item(spie_pkg::OP_SEEK, rand_index(), v);
                burst = $urandom_range(1, 10);
                next_burst(burst);
                made += 1 + burst;
            end else if (r < 82) begin
                burst = $urandom_range(1, 4);
                next_burst(burst);
                made += burst;
            end else if (r < 90) begin
                idx = rand_index();
                v = $urandom();
                push_item(spie_pkg::OP_WRITE, idx, v);
                if (32'(idx) <= MAX_SEG) begin
                    plan_ptr[idx] = v;
                    made++;
                end
            end else if (r < 96) begin
                push_item(spie_pkg::OP_SEEK, rand_index(), $urandom());
                made++;
            end else begin
                push_item(OP_RESERVED, rand_index(), $urandom());
            end
        end
    endtask

    // ---------------- test sequence ----------------

    initial begin
        for (int i = 0; i <= MAX_SEG; i++) begin
            seg_ptr[i]  = '0;
            plan_ptr[i] = '0;
        end
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: four segments, segment 1 empty, total 20
        begin_phase(34, 52, 32'd20, 32'd4);
        plan_ptr[0] = 32'd0;
        plan_ptr[1] = 32'd5;
        plan_ptr[2] = 32'd5;
        plan_ptr[3] = 32'd12;
        plan_ptr[4] = 32'd20;
        load_table(4);
        push_item(spie_pkg::OP_WRITE, 11'd1024, 32'hFFFF_FFFF);
        // writes above the table are dropped
        push_item(spie_pkg::OP_WRITE, 11'd2047, $urandom());
        push_item(spie_pkg::OP_WRITE, 11'd1025, 32'd0);
        push_item(OP_RESERVED, rand_index(), $urandom());
        push_item(spie_pkg::OP_SEEK, rand_index(), 32'd0);
        next_burst(3);
        // walk across the segment boundary and over the empty one
        push_item(spie_pkg::OP_SEEK, rand_index(), 32'd4);
        next_burst(2);
        // run off the last segment and beyond the total
        push_item(spie_pkg::OP_SEEK, rand_index(), 32'd19);
        next_burst(3);
        // position wraps to zero
        push_item(spie_pkg::OP_SEEK, rand_index(), 32'hFFFF_FFFF);
        next_burst(2);

        // single segment
        plan_table(1, 32'd0, 9);
        begin_phase(34, 52, plan_ptr[1], 32'd1);
        load_table(1);
        random_items(1, PHASE_ITEMS, 1'b1);

        // zero segment count acts as one; empty total, walk resumes without a seek
        begin_phase(34, 52, 32'd0, $urandom() & 32'hFFFF_F800);
        random_items(1, PHASE_ITEMS, 1'b0);

        plan_table(16, $urandom_range(0, 1000), 6);
        begin_phase(34, 52, plan_ptr[16], 32'd16);
        load_table(16);
        random_items(16, PHASE_ITEMS, 1'b1);

        // full table near the top of the position range
        plan_table(MAX_SEG, 32'hFFFF_0000, 40);
        begin_phase(52, 34, 32'hFFFF_FFFF, 32'(MAX_SEG));
        load_table(MAX_SEG);
        random_items(MAX_SEG, PHASE_ITEMS, 1'b1);

        // oversized segment count clamps to the table size
        begin_phase(52, 34, $urandom(), ($urandom() & 32'hFFFF_F800) | 32'h0000_07FF);
        random_items(MAX_SEG, PHASE_ITEMS, 1'b1);

        // shrink the count under the current segment, first walk without a seek
        begin_phase(52, 34, plan_ptr[3] + $urandom_range(0, 4), 32'd3);
        random_items(3, PHASE_ITEMS, 1'b0);

        plan_table(20, $urandom_range(0, 32'h7FFF_FFFF), 1000);
        begin_phase(0, 0, plan_ptr[20], 32'd20);
        load_table(20);
        random_items(20, PHASE_ITEMS, 1'b1);

        // total one short of the end pointer
        plan_table(8, 32'd0, 3);
        begin_phase(0, 0, (plan_ptr[8] == 32'd0) ? 32'd0 : plan_ptr[8] - 32'd1, 32'd8);
        load_table(8);
        random_items(8, PHASE_ITEMS, 1'b0);

        wait_idle();
        fail_count += expected_indices.size();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
